[rtl/core/rfhop_pkg.sv]
// shared types, constants and helpers of the rf channel hop sequencer
`timescale 1ns / 1ps
`default_nettype none

package rfhop_pkg;

  localparam int MAX_HOP_ENTRIES = 64;
  localparam int TABLE_DEPTH     = 64;

  localparam int CH_W   = 6;   // channel number and list position
  localparam int CNT_W  = 7;   // hop_count and table_size
  localparam int FREQ_W = 32;
  localparam int TIME_W = 32;
  localparam int LFSR_W = 16;
  localparam int LIST_AW = $clog2(MAX_HOP_ENTRIES);
  localparam int FREQ_AW = $clog2(TABLE_DEPTH);

  localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;
  localparam logic [3:0]        PERIOD_MULT = 4'd10;

  // input item kinds
  typedef enum logic [1:0] {
    FUNC_HOP      = 2'd0,
    FUNC_RESTART  = 2'd1,
    FUNC_LIST_WR  = 2'd2,
    FUNC_FREQ_WR  = 2'd3
  } func_t;

  // hop orders
  localparam logic [1:0] ORDER_SEQ    = 2'd0;
  localparam logic [1:0] ORDER_RANDOM = 2'd1;
  localparam logic [1:0] ORDER_STRIDE = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_HOP_ENABLE    = 3'd0;
  localparam logic [2:0] CFG_HOP_ORDER     = 3'd1;
  localparam logic [2:0] CFG_HOP_PERIOD    = 3'd2;
  localparam logic [2:0] CFG_HOP_COUNT     = 3'd3;
  localparam logic [2:0] CFG_FIXED_CHANNEL = 3'd4;
  localparam logic [2:0] CFG_TABLE_SIZE    = 3'd5;
  localparam logic [2:0] CFG_RANDOM_SEED   = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_LREAD,
    ST_DRAW,
    ST_TREAD,
    ST_OUT
  } state_t;

  // one step of the right-shifting galois lfsr
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] s;
    s = v >> 1;
    if (v[0]) s = s ^ LFSR_MASK;
    return s;
  endfunction

  // clamp a count into 1..limit
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c,
                                                   input logic [CNT_W-1:0] limit);
    logic [CNT_W-1:0] r;
    r = c;
    if (c == '0) r = CNT_W'(1);
    else if (c > limit) r = limit;
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/rfhop_ram.sv]
// generic single-port-write, registered-read synchronous ram
`timescale 1ns / 1ps
`default_nettype none

module rfhop_ram #(
  parameter int DW = 32,
  parameter int AW = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/rfhop_mod.sv]
// bit-serial remainder unit for lfsr draw mod hop count
`timescale 1ns / 1ps
`default_nettype none

module rfhop_mod
  import rfhop_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [LFSR_W-1:0] dividend,
  input  wire logic [CNT_W-1:0]  divisor,
  output logic                   done,
  output logic [CH_W-1:0]        remainder
);

  localparam int STEP_W = $clog2(LFSR_W);

  logic [LFSR_W-1:0] dvd_r;
  logic [CH_W-1:0]   rem_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  trial;
  logic [CH_W-1:0]   rem_nxt;

  // one restoring step per cycle, msb first
  always_comb begin
    trial = {rem_r, dvd_r[LFSR_W-1]};
    if (trial >= divisor) rem_nxt = CH_W'(trial - divisor);
    else                  rem_nxt = CH_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      cnt_r <= STEP_W'(LFSR_W - 1);
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - STEP_W'(1);
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

[rtl/core/rf_channel_hop_sequencer_top.sv]
// top level of the rf channel hop sequencer
`timescale 1ns / 1ps
`default_nettype none

// Picks the working RF channel and PLL frequency word for one reader context.
// Each input transaction carries a kind in in_tuser: hop request, restart,
// hop list write or frequency table write. Writes land on accept and give no
// result. Hop requests and restarts each give one result transaction. Items
// are handled one at a time: the hop list and frequency table sit in two
// synchronous RAMs with registered reads. A fixed-mode item passes the decide,
// table read and output states; a due hop or in-order restart also reads the
// hop list, and an item that draws a random position waits on the bit-serial
// remainder unit that works the 16-bit LFSR value mod hop_count one bit a
// cycle. The next item is taken once the previous result sits in the output
// register, even if it is still waiting to be taken. Hop list and frequency
// entries must be written before they are read. Configuration is written through
// cfg_we / cfg_index / cfg_wdata by the user, only while idle; it is not checked.

module rf_channel_hop_sequencer_top
  import rfhop_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // now_ms[31:0], entry_index[37:32], entry_value[69:38]
  input  wire logic [1:0]  in_tuser,   // func[1:0]
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // freq_word[31:0], work_channel[37:32], hopped[38],
                                       // channel_fault[39]
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  // configuration registers
  logic              hop_enable_r;
  logic [1:0]        hop_order_r;
  logic [15:0]       hop_period_r;
  logic [CNT_W-1:0]  hop_count_r;
  logic [CH_W-1:0]   fixed_channel_r;
  logic [CNT_W-1:0]  table_size_r;
  logic [LFSR_W-1:0] random_seed_r;

  // sequencer state
  state_t            state_r, state_nxt;
  func_t             func_r;
  logic [TIME_W-1:0] now_r;
  logic [CH_W-1:0]   pos_r, pos_nxt;
  logic [CH_W-1:0]   cur_r, cur_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;
  logic [LFSR_W-1:0] lfsr_r, lfsr_nxt;
  logic              hopped_r, hopped_nxt;
  logic              fault_r, fault_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [39:0]       out_data_r, out_data_nxt;

  // item fields
  logic              in_accept;
  func_t             in_func;
  logic [TIME_W-1:0] in_now;
  logic [CH_W-1:0]   in_index;
  logic [31:0]       in_value;

  // memory ports
  logic               list_we, list_re;
  logic [LIST_AW-1:0] list_raddr;
  logic [CH_W-1:0]    list_rdata;
  logic               freq_we, freq_re;
  logic [FREQ_AW-1:0] freq_raddr;
  logic [FREQ_W-1:0]  freq_rdata;

  // remainder unit
  logic              mod_start;
  logic [LFSR_W-1:0] mod_dividend;
  logic              mod_done;
  logic [CH_W-1:0]   mod_rem;

  // derived values
  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  ts_eff;
  logic [LFSR_W-1:0] seed_eff;
  logic [19:0]       dwell_ms;
  logic [TIME_W-1:0] elapsed;
  logic              hop_due;
  logic [CH_W-1:0]   p_eff;
  logic [CNT_W-1:0]  seq_next;
  logic [CH_W-1:0]   seq_pos;
  logic [CH_W-1:0]   half_span;
  logic [CNT_W:0]    stride_sum;
  logic [CNT_W:0]    stride_mod;
  logic [CH_W-1:0]   stride_pos;
  logic              random_order;

  assign in_func   = func_t'(in_tuser);
  assign in_now    = in_tdata[31:0];
  assign in_index  = in_tdata[37:32];
  assign in_value  = in_tdata[69:38];
  assign in_accept = in_tvalid && in_tready;
  // nothing is taken while reset is held
  assign in_tready = rst_n && (state_r == ST_IDLE);

  // table writes land directly on accept
  assign list_we = in_accept && (in_func == FUNC_LIST_WR) &&
                   (32'(in_index) < 32'(MAX_HOP_ENTRIES));
  assign freq_we = in_accept && (in_func == FUNC_FREQ_WR) &&
                   (32'(in_index) < 32'(TABLE_DEPTH));

  rfhop_ram #(.DW(CH_W), .AW(LIST_AW)) u_list_ram (
    .clk   (clk),
    .we    (list_we),
    .waddr (LIST_AW'(in_index)),
    .wdata (in_value[CH_W-1:0]),
    .re    (list_re),
    .raddr (list_raddr),
    .rdata (list_rdata)
  );

  rfhop_ram #(.DW(FREQ_W), .AW(FREQ_AW)) u_freq_ram (
    .clk   (clk),
    .we    (freq_we),
    .waddr (FREQ_AW'(in_index)),
    .wdata (in_value),
    .re    (freq_re),
    .raddr (freq_raddr),
    .rdata (freq_rdata)
  );

  rfhop_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (mod_dividend),
    .divisor   (n_eff),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // clamped counts, seed and dwell test
  always_comb begin
    n_eff    = clamp_count(hop_count_r, CNT_W'(MAX_HOP_ENTRIES));
    ts_eff   = clamp_count(table_size_r, CNT_W'(TABLE_DEPTH));
    seed_eff = (random_seed_r == '0) ? LFSR_W'(1) : random_seed_r;
    dwell_ms = 20'(hop_period_r) * 20'(PERIOD_MULT);
    elapsed  = now_r - last_r;
    hop_due  = elapsed > TIME_W'(dwell_ms);
    random_order = (hop_order_r == ORDER_RANDOM) || (hop_order_r == ORDER_STRIDE);
  end

  // next position for the sequential and stride orders
  always_comb begin
    // stale position after hop_count was lowered falls back to 0
    p_eff      = ({1'b0, pos_r} < n_eff) ? pos_r : '0;
    seq_next   = CNT_W'(p_eff) + CNT_W'(1);
    seq_pos    = (seq_next >= n_eff) ? '0 : CH_W'(seq_next);
    half_span  = CH_W'((n_eff - CNT_W'(1)) >> 1);
    stride_sum = (CNT_W+1)'(p_eff) + (CNT_W+1)'(1) + (CNT_W+1)'(half_span);
    stride_mod = (stride_sum >= (CNT_W+1)'(n_eff)) ? stride_sum - (CNT_W+1)'(n_eff)
                                                    : stride_sum;
    // zero wraps to n, then step back by one
    if (stride_mod == '0) stride_pos = CH_W'(n_eff - CNT_W'(1));
    else                  stride_pos = CH_W'(stride_mod - (CNT_W+1)'(1));
  end

  // sequencer: next state, memory reads and state updates
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    cur_nxt       = cur_r;
    last_nxt      = last_r;
    lfsr_nxt      = lfsr_r;
    hopped_nxt    = hopped_r;
    fault_nxt     = fault_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    list_re       = 1'b0;
    list_raddr    = '0;
    freq_re       = 1'b0;
    freq_raddr    = '0;
    mod_start     = 1'b0;
    mod_dividend  = '0;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_func == FUNC_HOP || in_func == FUNC_RESTART)) begin
          state_nxt = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        hopped_nxt = 1'b0;
        if (func_r == FUNC_RESTART) begin
          last_nxt = now_r;
          lfsr_nxt = seed_eff;
          if (!hop_enable_r) begin
            cur_nxt   = fixed_channel_r;
            state_nxt = ST_TREAD;
          end else if (random_order) begin
            // start position drawn from the reseeded lfsr
            lfsr_nxt     = lfsr_step(seed_eff);
            mod_start    = 1'b1;
            mod_dividend = lfsr_step(seed_eff);
            state_nxt    = ST_DRAW;
          end else begin
            pos_nxt    = '0;
            list_re    = 1'b1;
            list_raddr = '0;
            state_nxt  = ST_LREAD;
          end
        end else if (!hop_enable_r) begin
          cur_nxt   = fixed_channel_r;
          state_nxt = ST_TREAD;
        end else if (hop_due) begin
          last_nxt   = now_r;
          hopped_nxt = 1'b1;
          list_re    = 1'b1;
          list_raddr = LIST_AW'(p_eff);
          if (hop_order_r == ORDER_SEQ)         pos_nxt = seq_pos;
          else if (hop_order_r != ORDER_RANDOM) pos_nxt = stride_pos;
          else                                  pos_nxt = p_eff;
          state_nxt = ST_LREAD;
        end else begin
          state_nxt = ST_TREAD;
        end
      end

      ST_LREAD: begin
        cur_nxt = list_rdata;
        if (func_r == FUNC_HOP && hop_order_r == ORDER_RANDOM) begin
          // random order: next position drawn after the hop
          lfsr_nxt     = lfsr_step(lfsr_r);
          mod_start    = 1'b1;
          mod_dividend = lfsr_step(lfsr_r);
          state_nxt    = ST_DRAW;
        end else begin
          state_nxt = ST_TREAD;
        end
      end

      ST_DRAW: begin
        if (mod_done) begin
          pos_nxt = mod_rem;
          if (func_r == FUNC_RESTART) begin
            list_re    = 1'b1;
            list_raddr = LIST_AW'(mod_rem);
            state_nxt  = ST_LREAD;
          end else begin
            state_nxt = ST_TREAD;
          end
        end
      end

      ST_TREAD: begin
        // channel past the table end maps to entry 0
        fault_nxt  = ({1'b0, cur_r} >= ts_eff);
        freq_re    = 1'b1;
        freq_raddr = fault_nxt ? '0 : FREQ_AW'(cur_r);
        state_nxt  = ST_OUT;
      end

      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {fault_r, hopped_r, cur_r, freq_rdata};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hop_enable_r    <= 1'b0;
      hop_order_r     <= ORDER_SEQ;
      hop_period_r    <= '0;
      hop_count_r     <= CNT_W'(1);
      fixed_channel_r <= CH_W'(10);
      table_size_r    <= CNT_W'(64);
      random_seed_r   <= LFSR_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HOP_ENABLE:    hop_enable_r    <= cfg_wdata[0];
        CFG_HOP_ORDER:     hop_order_r     <= cfg_wdata[1:0];
        CFG_HOP_PERIOD:    hop_period_r    <= cfg_wdata;
        CFG_HOP_COUNT:     hop_count_r     <= cfg_wdata[CNT_W-1:0];
        CFG_FIXED_CHANNEL: fixed_channel_r <= cfg_wdata[CH_W-1:0];
        CFG_TABLE_SIZE:    table_size_r    <= cfg_wdata[CNT_W-1:0];
        CFG_RANDOM_SEED:   random_seed_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control and hop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      cur_r       <= CH_W'(10);
      last_r      <= '0;
      lfsr_r      <= LFSR_W'(1);
      hopped_r    <= 1'b0;
      fault_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      cur_r       <= cur_nxt;
      last_r      <= last_nxt;
      lfsr_r      <= lfsr_nxt;
      hopped_r    <= hopped_nxt;
      fault_r     <= fault_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_r <= in_func;
      now_r  <= in_now;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
